// ----- hdl/tnt_pkg.sv -----
// Package: payload types, arithmetic helpers for the triangle normal/tangent pipeline.
package tnt_pkg;

    // Coordinate format of the request fields
    localparam int COORD_WIDTH = 32;
    localparam int EDGE_WIDTH  = COORD_WIDTH + 1;
    localparam int OUT_WIDTH   = 32;

    // Iteration counts of the square root and the divider
    localparam int ROOT_STEPS = 32;
    localparam int QUOT_BITS  = 32;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [OUT_WIDTH-1:0]   unit_t;
    typedef logic signed [63:0]            wide_t;
    typedef logic signed [31:0]            scaled_t;

    typedef struct packed {
        coord_t vertex_a_x;
        coord_t vertex_a_y;
        coord_t vertex_a_z;
        coord_t vertex_b_x;
        coord_t vertex_b_y;
        coord_t vertex_b_z;
        coord_t vertex_c_x;
        coord_t vertex_c_y;
        coord_t vertex_c_z;
        coord_t tex_u_a;
        coord_t tex_u_b;
        coord_t tex_u_c;
    } tri_in_t;

    typedef struct packed {
        unit_t normal_x;
        unit_t normal_y;
        unit_t normal_z;
        unit_t tangent_x;
        unit_t tangent_y;
        unit_t tangent_z;
        logic  degenerate;
    } tri_out_t;

    // Result of one normalizer: unit vector and nonzero flag
    typedef struct packed {
        unit_t x;
        unit_t y;
        unit_t z;
        logic  ok;
    } unit_res_t;

    // Square root working state
    typedef struct packed {
        logic [63:0] x;
        logic [63:0] r;
    } sq_t;

    // Divider working state
    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] q;
    } dv_t;

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        logic [63:0] u;
        u = v;
        return v[63] ? (~u + 64'd1) : u;
    endfunction

    // Bit length of a magnitude (0 for zero)
    function automatic logic [6:0] msb_len(input logic [63:0] m);
        logic [6:0] len;
        len = '0;
        for (int i = 0; i < 64; i++) begin
            if (m[i]) begin
                len = 7'(i + 1);
            end
        end
        return len;
    endfunction

    // Block scale: shift so a group of bit length len peaks in [2^30, 2^31)
    function automatic logic [30:0] bscale_mag(input logic [63:0] m, input logic [6:0] len);
        logic [63:0] s;
        if (len > 7'd31) begin
            s = m >> (len - 7'd31);
        end else begin
            s = m << (7'd31 - len);
        end
        return s[30:0];
    endfunction

    function automatic scaled_t set_sign(input logic [30:0] m, input logic neg);
        logic [31:0] u;
        u = {1'b0, m};
        return neg ? (~u + 32'd1) : u;
    endfunction

    // One step of the bitwise integer square root
    function automatic sq_t sqrt_step(input sq_t s, input int it);
        logic [63:0] bit_v;
        logic [63:0] trial;
        sq_t         o;
        bit_v = 64'd1 << (62 - 2 * it);
        trial = s.r + bit_v;
        if (s.x >= trial) begin
            o.x = s.x - trial;
            o.r = (s.r >> 1) + bit_v;
        end else begin
            o.x = s.x;
            o.r = s.r >> 1;
        end
        return o;
    endfunction

    // One step of restoring division
    function automatic dv_t div_step(input dv_t d, input logic nb, input logic [31:0] den);
        logic [32:0] t;
        dv_t         o;
        t = {d.rem, nb};
        if (t >= {1'b0, den}) begin
            o.rem = 32'(t - {1'b0, den});
            o.q   = {d.q[30:0], 1'b1};
        end else begin
            o.rem = t[31:0];
            o.q   = {d.q[30:0], 1'b0};
        end
        return o;
    endfunction

endpackage

// ----- hdl/triangle_normal_tangent.sv -----
// Top level: triangle face normal and tangent pipeline.
// Accepts one triangle per clock while s_ready is high; returns one result per
// triangle, in order. Path: 13 front stages (edges, block scaling, cross
// products, texture gradient), 38 stages in each normalizer, one output register.
// Normalizer depth is set by the 32-step square root and the 32-step divider,
// each retiring two steps per stage. A stalled output holds the pipeline only
// when the last stage is full; bubbles keep draining. The user must write uv_mode
// through the cfg port while no request is in flight; the block won't enforce it.
module triangle_normal_tangent (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  tnt_pkg::tri_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output tnt_pkg::tri_out_t m_data
);
    localparam int EW        = tnt_pkg::EDGE_WIDTH;
    localparam int FRONT     = 13;
    localparam int N_DELAY   = 8;

    // Configuration register
    logic uv_mode_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            uv_mode_reg <= 1'b0;
        end else if (cfg_valid) begin
            uv_mode_reg <= cfg_data;
        end
    end

    // Pipeline advance
    logic                t_valid;
    tnt_pkg::unit_res_t  t_res;
    logic                n_valid;
    tnt_pkg::unit_res_t  n_res;
    logic                m_valid_reg;
    tnt_pkg::tri_out_t   m_data_reg;
    logic                adv;
    logic                out_load;

    assign out_load = !m_valid_reg || m_ready;
    assign adv      = out_load || !t_valid;
    assign s_ready  = adv;

    logic [FRONT:1] k_v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_v_reg <= '0;
        end else if (adv) begin
            k_v_reg <= {k_v_reg[FRONT-1:1], s_valid};
        end
    end

    // Front-end registers
    logic signed [EW-1:0] e_reg   [6];
    logic signed [EW-1:0] du_reg  [2];
    logic [63:0]          ed_mag_reg [6];
    logic [5:0]           ed_neg_reg;
    logic [6:0]           ed_len_reg;
    logic [63:0]          du_mag_reg [2];
    logic [1:0]           du_neg_reg;
    logic [6:0]           du_len_reg;
    logic signed [EW-1:0] e1_line_reg [2:FRONT][3];
    tnt_pkg::scaled_t     es_line_reg [3:7][6];
    tnt_pkg::scaled_t     dus_line_reg [3:11][2];
    logic [12:3]          du_nz_reg;
    tnt_pkg::wide_t       s4_prod_reg [6];
    tnt_pkg::wide_t       s5_cs_reg   [3];
    logic [63:0]          s6_mag_reg  [3];
    logic [2:0]           s6_neg_reg;
    logic [6:0]           s6_len_reg;
    tnt_pkg::scaled_t     s7_c_reg    [3];
    tnt_pkg::wide_t       s8_prod_reg [12];
    tnt_pkg::wide_t       s9_pq_reg   [6];
    logic [63:0]          s10_mag_reg [6];
    logic [5:0]           s10_neg_reg;
    logic [6:0]           s10_len_reg;
    tnt_pkg::scaled_t     s11_pq_reg  [6];
    logic                 s11_nz_reg;
    tnt_pkg::wide_t       s12_prod_reg [6];
    logic                 s12_nz_reg;
    tnt_pkg::wide_t       s13_t_reg   [3];
    logic                 s13_ok_reg;

    // Group bit lengths for block scaling
    logic [63:0] ed_or, du_or, cs_or, pq_or;
    logic [6:0]  ed_len_next, du_len_next, cs_len_next, pq_len_next;

    always_comb begin
        ed_or = '0;
        du_or = '0;
        cs_or = '0;
        pq_or = '0;
        for (int i = 0; i < 6; i++) begin
            ed_or = ed_or | tnt_pkg::mag64(64'(e_reg[i]));
            pq_or = pq_or | tnt_pkg::mag64(s9_pq_reg[i]);
        end
        for (int i = 0; i < 2; i++) begin
            du_or = du_or | tnt_pkg::mag64(64'(du_reg[i]));
        end
        for (int i = 0; i < 3; i++) begin
            cs_or = cs_or | tnt_pkg::mag64(s5_cs_reg[i]);
        end
        ed_len_next = tnt_pkg::msb_len(ed_or);
        du_len_next = tnt_pkg::msb_len(du_or);
        cs_len_next = tnt_pkg::msb_len(cs_or);
        pq_len_next = tnt_pkg::msb_len(pq_or);
    end

    // Front-end data path
    always_ff @(posedge aclk) begin
        if (adv) begin
            // Stage 1: edges and u differences
            e_reg[0]  <= EW'(s_data.vertex_b_x) - EW'(s_data.vertex_a_x);
            e_reg[1]  <= EW'(s_data.vertex_b_y) - EW'(s_data.vertex_a_y);
            e_reg[2]  <= EW'(s_data.vertex_b_z) - EW'(s_data.vertex_a_z);
            e_reg[3]  <= EW'(s_data.vertex_c_x) - EW'(s_data.vertex_a_x);
            e_reg[4]  <= EW'(s_data.vertex_c_y) - EW'(s_data.vertex_a_y);
            e_reg[5]  <= EW'(s_data.vertex_c_z) - EW'(s_data.vertex_a_z);
            du_reg[0] <= EW'(s_data.tex_u_b) - EW'(s_data.tex_u_a);
            du_reg[1] <= EW'(s_data.tex_u_c) - EW'(s_data.tex_u_a);

            // Stage 2: magnitudes for block scaling
            for (int i = 0; i < 6; i++) begin
                ed_mag_reg[i] <= tnt_pkg::mag64(64'(e_reg[i]));
                ed_neg_reg[i] <= e_reg[i][EW-1];
            end
            for (int i = 0; i < 2; i++) begin
                du_mag_reg[i] <= tnt_pkg::mag64(64'(du_reg[i]));
                du_neg_reg[i] <= du_reg[i][EW-1];
            end
            ed_len_reg <= ed_len_next;
            du_len_reg <= du_len_next;

            // Exact first edge for edge-mode tangent
            for (int i = 0; i < 3; i++) begin
                e1_line_reg[2][i] <= e_reg[i];
            end
            for (int k = 3; k <= FRONT; k++) begin
                e1_line_reg[k] <= e1_line_reg[k-1];
            end

            // Stage 3: scaled edges and u differences
            for (int i = 0; i < 6; i++) begin
                es_line_reg[3][i] <= tnt_pkg::set_sign(
                    tnt_pkg::bscale_mag(ed_mag_reg[i], ed_len_reg), ed_neg_reg[i]);
            end
            for (int i = 0; i < 2; i++) begin
                dus_line_reg[3][i] <= tnt_pkg::set_sign(
                    tnt_pkg::bscale_mag(du_mag_reg[i], du_len_reg), du_neg_reg[i]);
            end
            du_nz_reg[3] <= (du_len_reg != 7'd0);
            for (int k = 4; k <= 7; k++) begin
                es_line_reg[k] <= es_line_reg[k-1];
            end
            for (int k = 4; k <= 11; k++) begin
                dus_line_reg[k] <= dus_line_reg[k-1];
            end
            du_nz_reg[12:4] <= du_nz_reg[11:3];

            // Stage 4: partial products of e1' x e2'
            s4_prod_reg[0] <= es_line_reg[3][1] * es_line_reg[3][5];
            s4_prod_reg[1] <= es_line_reg[3][2] * es_line_reg[3][4];
            s4_prod_reg[2] <= es_line_reg[3][2] * es_line_reg[3][3];
            s4_prod_reg[3] <= es_line_reg[3][0] * es_line_reg[3][5];
            s4_prod_reg[4] <= es_line_reg[3][0] * es_line_reg[3][4];
            s4_prod_reg[5] <= es_line_reg[3][1] * es_line_reg[3][3];

            // Stage 5: cross product
            for (int i = 0; i < 3; i++) begin
                s5_cs_reg[i] <= s4_prod_reg[2*i] - s4_prod_reg[2*i+1];
            end

            // Stages 6-7: block-scale the cross product
            for (int i = 0; i < 3; i++) begin
                s6_mag_reg[i] <= tnt_pkg::mag64(s5_cs_reg[i]);
                s6_neg_reg[i] <= s5_cs_reg[i][63];
                s7_c_reg[i]   <= tnt_pkg::set_sign(
                    tnt_pkg::bscale_mag(s6_mag_reg[i], s6_len_reg), s6_neg_reg[i]);
            end
            s6_len_reg <= cs_len_next;

            // Stage 8: partial products of p = e2' x c' and q = c' x e1'
            s8_prod_reg[0]  <= es_line_reg[7][4] * s7_c_reg[2];
            s8_prod_reg[1]  <= es_line_reg[7][5] * s7_c_reg[1];
            s8_prod_reg[2]  <= es_line_reg[7][5] * s7_c_reg[0];
            s8_prod_reg[3]  <= es_line_reg[7][3] * s7_c_reg[2];
            s8_prod_reg[4]  <= es_line_reg[7][3] * s7_c_reg[1];
            s8_prod_reg[5]  <= es_line_reg[7][4] * s7_c_reg[0];
            s8_prod_reg[6]  <= s7_c_reg[1] * es_line_reg[7][2];
            s8_prod_reg[7]  <= s7_c_reg[2] * es_line_reg[7][1];
            s8_prod_reg[8]  <= s7_c_reg[2] * es_line_reg[7][0];
            s8_prod_reg[9]  <= s7_c_reg[0] * es_line_reg[7][2];
            s8_prod_reg[10] <= s7_c_reg[0] * es_line_reg[7][1];
            s8_prod_reg[11] <= s7_c_reg[1] * es_line_reg[7][0];

            // Stage 9: p and q
            for (int i = 0; i < 6; i++) begin
                s9_pq_reg[i] <= s8_prod_reg[2*i] - s8_prod_reg[2*i+1];
            end

            // Stages 10-11: block-scale p and q together
            for (int i = 0; i < 6; i++) begin
                s10_mag_reg[i] <= tnt_pkg::mag64(s9_pq_reg[i]);
                s10_neg_reg[i] <= s9_pq_reg[i][63];
                s11_pq_reg[i]  <= tnt_pkg::set_sign(
                    tnt_pkg::bscale_mag(s10_mag_reg[i], s10_len_reg), s10_neg_reg[i]);
            end
            s10_len_reg <= pq_len_next;
            s11_nz_reg  <= (s10_len_reg != 7'd0);

            // Stage 12: gradient products
            for (int i = 0; i < 3; i++) begin
                s12_prod_reg[i]   <= dus_line_reg[11][0] * s11_pq_reg[i];
                s12_prod_reg[3+i] <= dus_line_reg[11][1] * s11_pq_reg[3+i];
            end
            s12_nz_reg <= s11_nz_reg;

            // Stage 13: tangent direction
            for (int i = 0; i < 3; i++) begin
                s13_t_reg[i] <= s12_prod_reg[i] + s12_prod_reg[3+i];
            end
            s13_ok_reg <= s12_nz_reg && du_nz_reg[12];
        end
    end

    // Tangent source: exact first edge, or texture gradient (zero when degenerate)
    tnt_pkg::wide_t tin [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (!uv_mode_reg) begin
                tin[i] = 64'(e1_line_reg[FRONT][i]);
            end else if (s13_ok_reg) begin
                tin[i] = s13_t_reg[i];
            end else begin
                tin[i] = '0;
            end
        end
    end

    tnt_unit3 u_norm_unit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (k_v_reg[5]),
        .in_x      (s5_cs_reg[0]),
        .in_y      (s5_cs_reg[1]),
        .in_z      (s5_cs_reg[2]),
        .out_valid (n_valid),
        .out_res   (n_res)
    );

    tnt_unit3 u_tan_unit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (k_v_reg[FRONT]),
        .in_x      (tin[0]),
        .in_y      (tin[1]),
        .in_z      (tin[2]),
        .out_valid (t_valid),
        .out_res   (t_res)
    );

    // Normal delay to line up with the tangent
    tnt_pkg::unit_res_t n_line_reg [1:N_DELAY];
    logic [N_DELAY:1]   n_line_v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_line_v_reg <= '0;
        end else if (adv) begin
            n_line_v_reg <= {n_line_v_reg[N_DELAY-1:1], n_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            n_line_reg[1] <= n_res;
            for (int k = 2; k <= N_DELAY; k++) begin
                n_line_reg[k] <= n_line_reg[k-1];
            end
        end
    end

    // Output register
    logic               ok_all;
    tnt_pkg::unit_res_t n_fin;
    assign n_fin  = n_line_reg[N_DELAY];
    assign ok_all = n_fin.ok && t_res.ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= t_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg.normal_x   <= ok_all ? n_fin.x : '0;
            m_data_reg.normal_y   <= ok_all ? n_fin.y : '0;
            m_data_reg.normal_z   <= ok_all ? n_fin.z : '0;
            m_data_reg.tangent_x  <= ok_all ? t_res.x : '0;
            m_data_reg.tangent_y  <= ok_all ? t_res.y : '0;
            m_data_reg.tangent_z  <= ok_all ? t_res.z : '0;
            m_data_reg.degenerate <= !ok_all;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Checks
    a_lanes_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        t_valid == n_line_v_reg[N_DELAY])
        else $error("normal and tangent lanes out of step");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> k_v_reg[1])
        else $error("accepted request not in first stage");

    a_degenerate_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.degenerate |->
            m_data.normal_x == 0 && m_data.normal_y == 0 && m_data.normal_z == 0 &&
            m_data.tangent_x == 0 && m_data.tangent_y == 0 && m_data.tangent_z == 0)
        else $error("degenerate result carries nonzero vector");

    a_unit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.degenerate |->
            m_data.normal_x <= 32'sh4000_0000 && m_data.normal_x >= -32'sh4000_0000)
        else $error("normal component out of unit range");

endmodule

// ----- hdl/tnt_unit3.sv -----
// Pipelined 3-vector normalizer: block scale, sum of squares, square root, divide.
module tnt_unit3 (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  tnt_pkg::wide_t      in_x,
    input  tnt_pkg::wide_t      in_y,
    input  tnt_pkg::wide_t      in_z,
    output logic                out_valid,
    output tnt_pkg::unit_res_t  out_res
);
    localparam int LANES           = 3;
    localparam int STEPS_PER_STAGE = 2;
    localparam int SQRT_STAGES     = tnt_pkg::ROOT_STEPS / STEPS_PER_STAGE;
    localparam int DIV_STAGES      = tnt_pkg::QUOT_BITS / STEPS_PER_STAGE;

    tnt_pkg::wide_t in_v [LANES];
    assign in_v[0] = in_x;
    assign in_v[1] = in_y;
    assign in_v[2] = in_z;

    // Stage 1: magnitudes and group bit length
    logic [63:0]      u1_mag_reg [LANES];
    logic [LANES-1:0] u1_neg_reg;
    logic [6:0]       u1_len_reg;
    logic [6:0]       u1_len_next;
    logic [63:0]      in_or;

    always_comb begin
        in_or = '0;
        for (int l = 0; l < LANES; l++) begin
            in_or = in_or | tnt_pkg::mag64(in_v[l]);
        end
        u1_len_next = tnt_pkg::msb_len(in_or);
    end

    // Stage 2: scaled magnitudes; stage 3: squares
    logic [30:0]      u2_mag_reg [LANES];
    logic [LANES-1:0] u2_neg_reg;
    logic             u2_nz_reg;
    logic [30:0]      u3_mag_reg [LANES];
    logic [61:0]      u3_sq_reg  [LANES];
    logic [LANES-1:0] u3_neg_reg;
    logic             u3_nz_reg;

    // Square root stages; index 0 holds the sum of squares
    tnt_pkg::sq_t     rt_reg     [SQRT_STAGES+1];
    tnt_pkg::sq_t     rt_next    [SQRT_STAGES+1];
    logic [30:0]      rt_mag_reg [SQRT_STAGES+1][LANES];
    logic [LANES-1:0] rt_neg_reg [SQRT_STAGES+1];
    logic             rt_nz_reg  [SQRT_STAGES+1];

    always_comb begin
        tnt_pkg::sq_t s;
        rt_next[0] = rt_reg[0];
        for (int j = 0; j < SQRT_STAGES; j++) begin
            s = rt_reg[j];
            for (int k = 0; k < STEPS_PER_STAGE; k++) begin
                s = tnt_pkg::sqrt_step(s, j * STEPS_PER_STAGE + k);
            end
            rt_next[j+1] = s;
        end
    end

    // Divider stages; index 0 holds the rounded numerators
    tnt_pkg::dv_t     dv_reg   [DIV_STAGES+1][LANES];
    tnt_pkg::dv_t     dv_next  [DIV_STAGES+1][LANES];
    logic [61:0]      dn_reg   [DIV_STAGES+1][LANES];
    logic [31:0]      den_reg  [DIV_STAGES+1];
    logic [LANES-1:0] dneg_reg [DIV_STAGES+1];
    logic             dnz_reg  [DIV_STAGES+1];
    logic [31:0]      norm;
    logic [61:0]      num      [LANES];

    assign norm = rt_reg[SQRT_STAGES].r[31:0];

    always_comb begin
        tnt_pkg::dv_t d;
        int           st;
        for (int l = 0; l < LANES; l++) begin
            num[l] = {rt_mag_reg[SQRT_STAGES][l], 30'b0} + 62'(norm >> 1);
            dv_next[0][l] = dv_reg[0][l];
        end
        for (int j = 0; j < DIV_STAGES; j++) begin
            for (int l = 0; l < LANES; l++) begin
                d = dv_reg[j][l];
                for (int k = 0; k < STEPS_PER_STAGE; k++) begin
                    st = j * STEPS_PER_STAGE + k;
                    d  = tnt_pkg::div_step(d, dn_reg[j][l][tnt_pkg::QUOT_BITS-1-st], den_reg[j]);
                end
                dv_next[j+1][l] = d;
            end
        end
    end

    // Valid bits
    localparam int NV = 3 + SQRT_STAGES + 1 + DIV_STAGES + 1 + 1;
    logic [NV-1:0] v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[NV-2:0], in_valid};
        end
    end

    assign out_valid = v_reg[NV-1];

    // Data path
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < LANES; l++) begin
                u1_mag_reg[l] <= tnt_pkg::mag64(in_v[l]);
                u1_neg_reg[l] <= in_v[l][63];
                u2_mag_reg[l] <= tnt_pkg::bscale_mag(u1_mag_reg[l], u1_len_reg);
                u3_mag_reg[l] <= u2_mag_reg[l];
                u3_sq_reg[l]  <= u2_mag_reg[l] * u2_mag_reg[l];
                rt_mag_reg[0][l] <= u3_mag_reg[l];
            end
            u1_len_reg <= u1_len_next;
            u2_neg_reg <= u1_neg_reg;
            u2_nz_reg  <= (u1_len_reg != 7'd0);
            u3_neg_reg <= u2_neg_reg;
            u3_nz_reg  <= u2_nz_reg;

            rt_reg[0].x   <= 64'(u3_sq_reg[0]) + 64'(u3_sq_reg[1]) + 64'(u3_sq_reg[2]);
            rt_reg[0].r   <= '0;
            rt_neg_reg[0] <= u3_neg_reg;
            rt_nz_reg[0]  <= u3_nz_reg;
            for (int j = 1; j <= SQRT_STAGES; j++) begin
                rt_reg[j]     <= rt_next[j];
                rt_mag_reg[j] <= rt_mag_reg[j-1];
                rt_neg_reg[j] <= rt_neg_reg[j-1];
                rt_nz_reg[j]  <= rt_nz_reg[j-1];
            end

            // Divider load: remainder starts from the high half of the numerator
            for (int l = 0; l < LANES; l++) begin
                dn_reg[0][l]     <= num[l];
                dv_reg[0][l].rem <= 32'(num[l][61:tnt_pkg::QUOT_BITS]);
                dv_reg[0][l].q   <= '0;
            end
            den_reg[0]  <= norm;
            dneg_reg[0] <= rt_neg_reg[SQRT_STAGES];
            dnz_reg[0]  <= rt_nz_reg[SQRT_STAGES];
            for (int j = 1; j <= DIV_STAGES; j++) begin
                dv_reg[j]   <= dv_next[j];
                dn_reg[j]   <= dn_reg[j-1];
                den_reg[j]  <= den_reg[j-1];
                dneg_reg[j] <= dneg_reg[j-1];
                dnz_reg[j]  <= dnz_reg[j-1];
            end

            // Signed result
            out_res.x  <= tnt_pkg::set_sign(dv_reg[DIV_STAGES][0].q[30:0], dneg_reg[DIV_STAGES][0]);
            out_res.y  <= tnt_pkg::set_sign(dv_reg[DIV_STAGES][1].q[30:0], dneg_reg[DIV_STAGES][1]);
            out_res.z  <= tnt_pkg::set_sign(dv_reg[DIV_STAGES][2].q[30:0], dneg_reg[DIV_STAGES][2]);
            out_res.ok <= dnz_reg[DIV_STAGES];
        end
    end

endmodule
